### rtl/fkj_pkg.sv
// Shared types, constants and helper functions for the leg kinematics Jacobian unit.
package fkj_pkg;

   localparam int NUM_JOINTS = 6;
   localparam int MAX_STEPS  = 24;
   localparam int OUT_W      = 18;
   localparam int ANG_W      = 16;
   localparam int TH_W       = 35;
   localparam int XY_W       = 33;

   localparam logic signed [TH_W-1:0] PI_Q30          = 35'sd3373259426;
   localparam logic signed [TH_W-1:0] HALF_PI_Q30     = 35'sd1686629713;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

   typedef logic [2:0] joint_idx_type;
   typedef logic [1:0] axis_type;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   localparam joint_idx_type LAST_JOINT = 3'd5;

   function automatic axis_type joint_axis(input joint_idx_type j);
      axis_type a;
      case (j)
         3'd0, 3'd2, 3'd3: a = AXIS_Y;
         3'd1, 3'd4:       a = AXIS_X;
         default:          a = AXIS_Z;
      endcase
      return a;
   endfunction

   function automatic axis_type axis_next(input axis_type a);
      axis_type n;
      case (a)
         AXIS_X:  n = AXIS_Y;
         AXIS_Y:  n = AXIS_Z;
         default: n = AXIS_X;
      endcase
      return n;
   endfunction

   function automatic logic signed [TH_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [TH_W-1:0] t;
      case (i)
         5'd0:    t = 35'sh03243F6A8;
         5'd1:    t = 35'sh01DAC6705;
         5'd2:    t = 35'sh00FADBAFC;
         5'd3:    t = 35'sh007F56EA6;
         5'd4:    t = 35'sh003FEAB76;
         5'd5:    t = 35'sh001FFD55B;
         5'd6:    t = 35'sh000FFFAAA;
         5'd7:    t = 35'sh0007FFF55;
         5'd8:    t = 35'sh0003FFFEA;
         5'd9:    t = 35'sh0001FFFFD;
         5'd10:   t = 35'sh0000FFFFF;
         5'd11:   t = 35'sh00007FFFF;
         5'd12:   t = 35'sh00003FFFF;
         5'd13:   t = 35'sh00001FFFF;
         5'd14:   t = 35'sh00000FFFF;
         5'd15:   t = 35'sh000007FFF;
         5'd16:   t = 35'sh000003FFF;
         5'd17:   t = 35'sh000001FFF;
         5'd18:   t = 35'sh000000FFF;
         5'd19:   t = 35'sh0000007FF;
         5'd20:   t = 35'sh0000003FF;
         5'd21:   t = 35'sh0000001FF;
         5'd22:   t = 35'sh0000000FF;
         5'd23:   t = 35'sh00000007F;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [47:0] v);
      logic signed [OUT_W-1:0] s;
      if (v > 48'sd131071) begin
         s = 18'sd131071;
      end else if (v < -48'sd131072) begin
         s = -18'sd131072;
      end else begin
         s = v[OUT_W-1:0];
      end
      return s;
   endfunction

endpackage

### rtl/fkj_cordic_lane.sv
// One CORDIC lane: negates a joint angle and iterates sine and cosine one step a cycle.
module fkj_cordic_lane import fkj_pkg::*; #(
   parameter int LEN_FRAC_BITS = 16,
   parameter int CORDIC_STEPS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [ANG_W-1:0]       angle,
   output logic                          done,
   output logic signed [LEN_FRAC_BITS+3:0] sin_val,
   output logic signed [LEN_FRAC_BITS+3:0] cos_val
);

   localparam int W     = LEN_FRAC_BITS + 4;
   localparam int NSTEP = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
   localparam int CNT_W = $clog2(NSTEP + 1);
   localparam int SH    = 30 - LEN_FRAC_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} lane_state_type;

   lane_state_type         state_ff;
   logic [CNT_W-1:0]       step_ff;
   logic signed [TH_W-1:0] th_ff;
   logic signed [XY_W-1:0] x_ff, y_ff;
   logic                   flip_ff;
   logic                   done_ff;
   logic signed [W-1:0]    sin_ff, cos_ff;

   logic signed [TH_W-1:0] th_neg, th_raw, th_in;
   logic                   flip_in;
   logic signed [XY_W-1:0] dx, dy, x_in, y_in, x_r, y_r;
   logic signed [TH_W-1:0] th_step_in;
   logic signed [TH_W-1:0] atan_v;

   always_comb begin
      th_neg = -TH_W'(angle);
      th_raw = th_neg <<< 17;
      if (th_raw > HALF_PI_Q30) begin
         th_in   = th_raw - PI_Q30;
         flip_in = 1'b1;
      end else if (th_raw < -HALF_PI_Q30) begin
         th_in   = th_raw + PI_Q30;
         flip_in = 1'b1;
      end else begin
         th_in   = th_raw;
         flip_in = 1'b0;
      end
      atan_v = atan_q30(5'(step_ff));
      dx     = y_ff >>> step_ff;
      dy     = x_ff >>> step_ff;
      if (!th_ff[TH_W-1]) begin
         x_in       = x_ff - dx;
         y_in       = y_ff + dy;
         th_step_in = th_ff - atan_v;
      end else begin
         x_in       = x_ff + dx;
         y_in       = y_ff - dy;
         th_step_in = th_ff + atan_v;
      end
      x_r = (x_ff + (XY_W'(1) <<< (SH - 1))) >>> SH;
      y_r = (y_ff + (XY_W'(1) <<< (SH - 1))) >>> SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == ST_FIN);
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  th_ff    <= th_in;
                  flip_ff  <= flip_in;
                  x_ff     <= CORDIC_GAIN_Q30;
                  y_ff     <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               th_ff   <= th_step_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == CNT_W'(NSTEP - 1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               cos_ff   <= flip_ff ? -W'(x_r) : W'(x_r);
               sin_ff   <= flip_ff ? -W'(y_r) : W'(y_r);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

### rtl/fkj_chain.sv
// Frame chaining and Jacobian column sequencer on one shared multiply-accumulate unit.
module fkj_chain import fkj_pkg::*; #(
   parameter int LEN_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            leg_side,
   input  logic signed [LEN_FRAC_BITS+3:0] sin_vals [NUM_JOINTS],
   input  logic signed [LEN_FRAC_BITS+3:0] cos_vals [NUM_JOINTS],
   output logic                            done,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_column_index,
   output logic signed [OUT_W-1:0]         rsp_linear_x,
   output logic signed [OUT_W-1:0]         rsp_linear_y,
   output logic signed [OUT_W-1:0]         rsp_linear_z,
   output logic signed [OUT_W-1:0]         rsp_angular_x,
   output logic signed [OUT_W-1:0]         rsp_angular_y,
   output logic signed [OUT_W-1:0]         rsp_angular_z,
   output logic signed [OUT_W-1:0]         rsp_end_x,
   output logic signed [OUT_W-1:0]         rsp_end_y,
   output logic signed [OUT_W-1:0]         rsp_end_z,
   output logic                            rsp_last_column
);

   localparam int W  = LEN_FRAC_BITS + 4;
   localparam int PW = 2 * W + 2;
   localparam int AW = 2 * W + 4;

   localparam longint ONE_L     = 64'sd1 << LEN_FRAC_BITS;
   localparam longint B_KNEE_X  = -((23 * ONE_L + 500) / 1000);
   localparam longint B_THIGH_Z = (35 * ONE_L + 50) / 100;
   localparam longint B_HR_Y    = (3 * ONE_L + 50) / 100;
   localparam longint B_HY_Y    = (47 * ONE_L + 500) / 1000;
   localparam longint B_HY_Z    = (985 * ONE_L + 5000) / 10000;

   typedef enum logic [2:0] {ST_IDLE, ST_POS, ST_ROT, ST_SAVE, ST_JAC, ST_EMIT}
      chain_state_type;

   chain_state_type     state_ff;
   joint_idx_type       j_ff;
   axis_type            r_ff;
   logic [1:0]          k_ff;
   logic signed [W-1:0] rot_ff [3][3];
   logic signed [W-1:0] p_ff [3];
   logic signed [W-1:0] a_ff [NUM_JOINTS][3];
   logic signed [W-1:0] q_ff [NUM_JOINTS][3];
   logic signed [W-1:0] lin_ff [3];
   logic signed [W-1:0] tmp_ff;
   logic signed [AW-1:0] acc_ff;
   logic                done_ff;
   logic                out_valid_ff;
   logic [2:0]          idx_ff;
   logic signed [OUT_W-1:0] lx_ff, ly_ff, lz_ff, ax_ff, ay_ff, az_ff, ex_ff, ey_ff, ez_ff;
   logic                last_ff;

   axis_type            ax, u, v, i1, i2, ia, id;
   logic signed [W-1:0] b_vec [3];
   logic signed [W:0]   opa, opb;
   logic signed [PW-1:0] prod;
   logic signed [AW-1:0] base, acc_in;
   logic                neg;
   logic signed [AW-1:0] rnd_full;
   logic signed [W-1:0] rnd_val;
   logic                emit_go;

   assign emit_go = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ready);

   always_comb begin
      ax = joint_axis(j_ff);
      u  = axis_next(ax);
      v  = axis_next(u);
      i1 = axis_next(r_ff);
      i2 = axis_next(i1);
      ia = k_ff[0] ? i2 : i1;
      id = k_ff[0] ? i1 : i2;

      b_vec[0] = '0;
      b_vec[1] = '0;
      b_vec[2] = '0;
      case (j_ff)
         3'd2: begin
            b_vec[0] = W'(B_KNEE_X);
            b_vec[2] = W'(B_THIGH_Z);
         end
         3'd3: b_vec[2] = W'(B_THIGH_Z);
         3'd4: b_vec[1] = leg_side ? -W'(B_HR_Y) : W'(B_HR_Y);
         3'd5: begin
            b_vec[1] = leg_side ? -W'(B_HY_Y) : W'(B_HY_Y);
            b_vec[2] = W'(B_HY_Z);
         end
         default: b_vec[0] = '0;
      endcase

      opa  = '0;
      opb  = '0;
      base = '0;
      neg  = 1'b0;
      case (state_ff)
         ST_POS: begin
            opa  = (W+1)'(rot_ff[r_ff][k_ff]);
            opb  = (W+1)'(b_vec[k_ff]);
            base = (k_ff == 2'd0) ? '0 : acc_ff;
         end
         ST_ROT: begin
            opa  = k_ff[0] ? (W+1)'(rot_ff[r_ff][v]) : (W+1)'(rot_ff[r_ff][u]);
            opb  = (k_ff == 2'd0 || k_ff == 2'd3) ? (W+1)'(cos_vals[j_ff])
                                                 : (W+1)'(sin_vals[j_ff]);
            neg  = (k_ff == 2'd2);
            base = k_ff[0] ? acc_ff : '0;
         end
         ST_JAC: begin
            opa  = (W+1)'(a_ff[j_ff][ia]);
            opb  = (W+1)'(p_ff[id]) - (W+1)'(q_ff[j_ff][id]);
            neg  = k_ff[0];
            base = k_ff[0] ? acc_ff : '0;
         end
         default: begin
            opa = '0;
         end
      endcase
      prod     = opa * opb;
      acc_in   = neg ? base - AW'(prod) : base + AW'(prod);
      rnd_full = (acc_in + (AW'(1) <<< (LEN_FRAC_BITS - 1))) >>> LEN_FRAC_BITS;
      rnd_val  = W'(rnd_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         done_ff <= emit_go && (j_ff == LAST_JOINT);
         if (emit_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  for (int r = 0; r < 3; r++) begin
                     p_ff[r] <= '0;
                     for (int c = 0; c < 3; c++) begin
                        rot_ff[r][c] <= (r == c) ? W'(ONE_L) : '0;
                     end
                  end
                  j_ff     <= '0;
                  r_ff     <= AXIS_X;
                  k_ff     <= '0;
                  state_ff <= ST_POS;
               end
            end
            ST_POS: begin
               acc_ff <= acc_in;
               if (k_ff == 2'd2) begin
                  p_ff[r_ff] <= p_ff[r_ff] + rnd_val;
                  k_ff       <= '0;
                  if (r_ff == AXIS_Z) begin
                     r_ff     <= AXIS_X;
                     state_ff <= ST_ROT;
                  end else begin
                     r_ff <= r_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_ROT: begin
               acc_ff <= acc_in;
               k_ff   <= k_ff + 1'b1;
               if (k_ff == 2'd1) begin
                  tmp_ff <= rnd_val;
               end
               if (k_ff == 2'd3) begin
                  rot_ff[r_ff][u] <= tmp_ff;
                  rot_ff[r_ff][v] <= rnd_val;
                  if (r_ff == AXIS_Z) begin
                     r_ff     <= AXIS_X;
                     state_ff <= ST_SAVE;
                  end else begin
                     r_ff <= r_ff + 1'b1;
                  end
               end
            end
            ST_SAVE: begin
               for (int r = 0; r < 3; r++) begin
                  a_ff[j_ff][r] <= rot_ff[r][ax];
                  q_ff[j_ff][r] <= p_ff[r];
               end
               k_ff <= '0;
               r_ff <= AXIS_X;
               if (j_ff == LAST_JOINT) begin
                  j_ff     <= '0;
                  state_ff <= ST_JAC;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_POS;
               end
            end
            ST_JAC: begin
               acc_ff <= acc_in;
               if (k_ff[0]) begin
                  lin_ff[r_ff] <= rnd_val;
                  k_ff         <= '0;
                  if (r_ff == AXIS_Z) begin
                     r_ff     <= AXIS_X;
                     state_ff <= ST_EMIT;
                  end else begin
                     r_ff <= r_ff + 1'b1;
                  end
               end else begin
                  k_ff <= 2'd1;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  idx_ff       <= j_ff;
                  lx_ff        <= sat_out(48'(lin_ff[0]));
                  ly_ff        <= sat_out(48'(lin_ff[1]));
                  lz_ff        <= sat_out(48'(lin_ff[2]));
                  ax_ff        <= sat_out(48'(a_ff[j_ff][0]));
                  ay_ff        <= sat_out(48'(a_ff[j_ff][1]));
                  az_ff        <= sat_out(48'(a_ff[j_ff][2]));
                  ex_ff        <= sat_out(48'(p_ff[0]));
                  ey_ff        <= sat_out(48'(p_ff[1]));
                  ez_ff        <= sat_out(48'(p_ff[2]));
                  last_ff      <= (j_ff == LAST_JOINT);
                  if (j_ff == LAST_JOINT) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_JAC;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign done             = done_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_column_index = idx_ff;
   assign rsp_linear_x     = lx_ff;
   assign rsp_linear_y     = ly_ff;
   assign rsp_linear_z     = lz_ff;
   assign rsp_angular_x    = ax_ff;
   assign rsp_angular_y    = ay_ff;
   assign rsp_angular_z    = az_ff;
   assign rsp_end_x        = ex_ff;
   assign rsp_end_y        = ey_ff;
   assign rsp_end_z        = ez_ff;
   assign rsp_last_column  = last_ff;

endmodule

### rtl/leg_forward_kinematics_jacobian_unit.sv
// Top level of the leg forward kinematics and geometric Jacobian unit.
// Takes six joint angles (Q3.13 rad) per request word and returns six response words,
// one Jacobian column each, in column order, the sixth flagged by last_column.
// Six CORDIC lanes produce all sines and cosines together; one shared multiply-accumulate
// unit then chains the six frames joint by joint and forms the columns one after another,
// so a new request word is not taken until the whole request is through, and a response
// word that waits on rsp_ready holds the chain back. A new request word is taken once
// the chain's done flag and then busy_ff are registered after the sixth column is loaded
// into the output register. leg_side (csr) selects right (0) or left (1) leg.
module leg_forward_kinematics_jacobian_unit import fkj_pkg::*; #(
   parameter int LEN_FRAC_BITS = 16,
   parameter int CORDIC_STEPS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [ANG_W-1:0] req_angle_ankle_pitch,
   input  logic signed [ANG_W-1:0] req_angle_ankle_roll,
   input  logic signed [ANG_W-1:0] req_angle_knee_pitch,
   input  logic signed [ANG_W-1:0] req_angle_hip_pitch,
   input  logic signed [ANG_W-1:0] req_angle_hip_roll,
   input  logic signed [ANG_W-1:0] req_angle_hip_yaw,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_column_index,
   output logic signed [OUT_W-1:0] rsp_linear_x,
   output logic signed [OUT_W-1:0] rsp_linear_y,
   output logic signed [OUT_W-1:0] rsp_linear_z,
   output logic signed [OUT_W-1:0] rsp_angular_x,
   output logic signed [OUT_W-1:0] rsp_angular_y,
   output logic signed [OUT_W-1:0] rsp_angular_z,
   output logic signed [OUT_W-1:0] rsp_end_x,
   output logic signed [OUT_W-1:0] rsp_end_y,
   output logic signed [OUT_W-1:0] rsp_end_z,
   output logic                    rsp_last_column,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data
);

   localparam int W = LEN_FRAC_BITS + 4;

   logic                    busy_ff;
   logic                    leg_side_ff;
   logic                    req_fire;
   logic                    chain_done;
   logic                    lane_done [NUM_JOINTS];
   logic signed [ANG_W-1:0] angles [NUM_JOINTS];
   logic signed [W-1:0]     sin_vals [NUM_JOINTS];
   logic signed [W-1:0]     cos_vals [NUM_JOINTS];

   assign angles[0] = req_angle_ankle_pitch;
   assign angles[1] = req_angle_ankle_roll;
   assign angles[2] = req_angle_knee_pitch;
   assign angles[3] = req_angle_hip_pitch;
   assign angles[4] = req_angle_hip_roll;
   assign angles[5] = req_angle_hip_yaw;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         leg_side_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            leg_side_ff <= csr_write_data;
         end
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (chain_done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   for (genvar g = 0; g < NUM_JOINTS; g++) begin : g_lane
      fkj_cordic_lane #(
         .LEN_FRAC_BITS (LEN_FRAC_BITS),
         .CORDIC_STEPS  (CORDIC_STEPS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (req_fire),
         .angle   (angles[g]),
         .done    (lane_done[g]),
         .sin_val (sin_vals[g]),
         .cos_val (cos_vals[g])
      );
   end

   fkj_chain #(
      .LEN_FRAC_BITS (LEN_FRAC_BITS)
   ) u_chain (
      .clock            (clock),
      .reset            (reset),
      .start            (lane_done[0] & lane_done[NUM_JOINTS-1]),
      .leg_side         (leg_side_ff),
      .sin_vals         (sin_vals),
      .cos_vals         (cos_vals),
      .done             (chain_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column_index (rsp_column_index),
      .rsp_linear_x     (rsp_linear_x),
      .rsp_linear_y     (rsp_linear_y),
      .rsp_linear_z     (rsp_linear_z),
      .rsp_angular_x    (rsp_angular_x),
      .rsp_angular_y    (rsp_angular_y),
      .rsp_angular_z    (rsp_angular_z),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_end_z        (rsp_end_z),
      .rsp_last_column  (rsp_last_column)
   );

endmodule

### dv/testbench.sv
// Testbench for the leg forward kinematics and geometric Jacobian unit.
`timescale 1ns / 100ps

module testbench import fkj_pkg::*;;

   localparam int FRAC        = 16;
   localparam int STEPS       = 16;
   localparam int STALL_LIMIT = 6000;

   typedef struct {
      logic [2:0]              column_index;
      logic signed [OUT_W-1:0] linear_x, linear_y, linear_z;
      logic signed [OUT_W-1:0] angular_x, angular_y, angular_z;
      logic signed [OUT_W-1:0] end_x, end_y, end_z;
      logic                    last_column;
   } jacobian_column_type;

   typedef logic signed [ANG_W-1:0] joint_angles_type [NUM_JOINTS];

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [ANG_W-1:0] req_angle_ankle_pitch, req_angle_ankle_roll, req_angle_knee_pitch;
   logic signed [ANG_W-1:0] req_angle_hip_pitch, req_angle_hip_roll, req_angle_hip_yaw;
   logic [2:0] rsp_column_index;
   logic signed [OUT_W-1:0] rsp_linear_x, rsp_linear_y, rsp_linear_z;
   logic signed [OUT_W-1:0] rsp_angular_x, rsp_angular_y, rsp_angular_z;
   logic signed [OUT_W-1:0] rsp_end_x, rsp_end_y, rsp_end_z;
   logic rsp_last_column;
   logic csr_write_enable, csr_write_data;

   jacobian_column_type expected_columns[$];
   logic leg_side;
   int   failures;
   int   idle_cycles;
   int   stall_left;

   leg_forward_kinematics_jacobian_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_angle_ankle_pitch(req_angle_ankle_pitch),
      .req_angle_ankle_roll(req_angle_ankle_roll),
      .req_angle_knee_pitch(req_angle_knee_pitch),
      .req_angle_hip_pitch(req_angle_hip_pitch),
      .req_angle_hip_roll(req_angle_hip_roll),
      .req_angle_hip_yaw(req_angle_hip_yaw),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_column_index(rsp_column_index),
      .rsp_linear_x(rsp_linear_x), .rsp_linear_y(rsp_linear_y), .rsp_linear_z(rsp_linear_z),
      .rsp_angular_x(rsp_angular_x), .rsp_angular_y(rsp_angular_y),
      .rsp_angular_z(rsp_angular_z),
      .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y), .rsp_end_z(rsp_end_z),
      .rsp_last_column(rsp_last_column),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint round_frac(longint v);
      return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint offset_len(longint num, longint den);
      return (num * (64'sd1 <<< FRAC) + den / 2) / den;
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
      if (v > 131071) return 18'sd131071;
      if (v < -131072) return -18'sd131072;
      return v[OUT_W-1:0];
   endfunction

   task automatic cordic_sin_cos(input longint angle, output longint sn, output longint cs);
      longint th, x, y, dx, dy;
      bit     flip;
      int     n;
      th = angle;
      x = CORDIC_GAIN_Q30;
      y = 0;
      flip = 0;
      n = (STEPS < MAX_STEPS) ? STEPS : MAX_STEPS;
      if (th > HALF_PI_Q30) begin
         th -= PI_Q30;
         flip = 1;
      end else if (th < -HALF_PI_Q30) begin
         th += PI_Q30;
         flip = 1;
      end
      for (int i = 0; i < n; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (th >= 0) begin
            x -= dx; y += dy; th -= atan_q30(5'(i));
         end else begin
            x += dx; y -= dy; th += atan_q30(5'(i));
         end
      end
      x = (x + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      y = (y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   task automatic predict_jacobian(input joint_angles_type ang);
      longint rot [7][3][3];
      longint pos [7][3];
      longint ofs [7][3];
      longint m [3][3];
      longint a [3], d [3], lin [3];
      longint sn, cs, acc, q, one, sgn;
      int ax, u, v;
      jacobian_column_type col;
      one = 64'sd1 <<< FRAC;
      sgn = leg_side ? -1 : 1;
      foreach (ofs[j, r]) ofs[j][r] = 0;
      ofs[3][0] = -offset_len(23, 1000);
      ofs[3][2] = offset_len(35, 100);
      ofs[4][2] = offset_len(35, 100);
      ofs[5][1] = sgn * offset_len(3, 100);
      ofs[6][1] = sgn * offset_len(47, 1000);
      ofs[6][2] = offset_len(985, 10000);
      for (int r = 0; r < 3; r++) begin
         pos[0][r] = 0;
         for (int c = 0; c < 3; c++) rot[0][r][c] = (r == c) ? one : 0;
      end
      for (int j = 1; j <= NUM_JOINTS; j++) begin
         q = -longint'(ang[j-1]) * 131072;
         cordic_sin_cos(q, sn, cs);
         ax = joint_axis(joint_idx_type'(j - 1));
         u = (ax + 1) % 3;
         v = (ax + 2) % 3;
         foreach (m[r, c]) m[r][c] = 0;
         m[ax][ax] = one;
         m[u][u] = cs; m[v][v] = cs;
         m[u][v] = -sn; m[v][u] = sn;
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rot[j-1][r][k] * ofs[j][k];
            pos[j][r] = pos[j-1][r] + round_frac(acc);
            for (int c = 0; c < 3; c++) begin
               acc = 0;
               for (int k = 0; k < 3; k++) acc += rot[j-1][r][k] * m[k][c];
               rot[j][r][c] = round_frac(acc);
            end
         end
      end
      for (int j = 1; j <= NUM_JOINTS; j++) begin
         ax = joint_axis(joint_idx_type'(j - 1));
         for (int r = 0; r < 3; r++) begin
            a[r] = rot[j][r][ax];
            d[r] = pos[6][r] - pos[j][r];
         end
         lin[0] = round_frac(a[1] * d[2] - a[2] * d[1]);
         lin[1] = round_frac(a[2] * d[0] - a[0] * d[2]);
         lin[2] = round_frac(a[0] * d[1] - a[1] * d[0]);
         col.column_index = 3'(j - 1);
         col.linear_x = clamp_out(lin[0]);
         col.linear_y = clamp_out(lin[1]);
         col.linear_z = clamp_out(lin[2]);
         col.angular_x = clamp_out(a[0]);
         col.angular_y = clamp_out(a[1]);
         col.angular_z = clamp_out(a[2]);
         col.end_x = clamp_out(pos[6][0]);
         col.end_y = clamp_out(pos[6][1]);
         col.end_z = clamp_out(pos[6][2]);
         col.last_column = (j == NUM_JOINTS);
         expected_columns.push_back(col);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_angles(input joint_angles_type ang);
      int gap;
      req_valid <= 1'b1;
      req_angle_ankle_pitch <= ang[0];
      req_angle_ankle_roll <= ang[1];
      req_angle_knee_pitch <= ang[2];
      req_angle_hip_pitch <= ang[3];
      req_angle_hip_roll <= ang[4];
      req_angle_hip_yaw <= ang[5];
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_jacobian(ang);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_set_side(input logic side);
      req_valid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= side;
      @(posedge clock);
      leg_side = side;
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [ANG_W-1:0] random_angle();
      int r;
      r = $urandom_range(9);
      if (r < 5) return ANG_W'($urandom());
      if (r < 7) return ANG_W'($urandom_range(0, 25736) - 12868);
      if (r < 8) return ANG_W'(12868 + $urandom_range(0, 2) - 1);
      if (r < 9) return ANG_W'(-12868 + $urandom_range(0, 2) - 1);
      return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
   endfunction

   task automatic run_directed();
      logic signed [ANG_W-1:0] pattern [12][NUM_JOINTS] = '{
         '{0, 0, 0, 0, 0, 0},
         '{32767, 32767, 32767, 32767, 32767, 32767},
         '{-32768, -32768, -32768, -32768, -32768, -32768},
         '{12868, -12868, 12867, -12867, 12868, -12868},
         '{25736, -25736, 25735, -25735, 0, 1},
         '{-1, 1, -1, 1, -1, 1},
         '{0, 0, -8192, 8192, 0, 0},
         '{4096, 0, 0, 0, 0, 0},
         '{0, 4096, 0, 0, 0, 0},
         '{0, 0, 0, 0, 4096, 0},
         '{0, 0, 0, 0, 0, 12868},
         '{-32768, 32767, -32768, 32767, -32768, 32767}
      };
      joint_angles_type ang;
      foreach (pattern[i]) begin
         foreach (ang[k]) ang[k] = pattern[i][k];
         send_angles(ang);
      end
   endtask

   task automatic run_random(input int count);
      joint_angles_type ang;
      repeat (count) begin
         foreach (ang[k]) ang[k] = random_angle();
         send_angles(ang);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_columns.size() == 0) begin
               $error("unexpected word: column_index %0d", rsp_column_index);
               failures++;
            end else begin
               jacobian_column_type e;
               e = expected_columns.pop_front();
               if (rsp_column_index !== e.column_index) begin
                  $error("column_index exp %0d got %0d", e.column_index, rsp_column_index);
                  failures++;
               end
               if (rsp_linear_x !== e.linear_x) begin
                  $error("linear_x exp %0d got %0d", e.linear_x, rsp_linear_x);
                  failures++;
               end
               if (rsp_linear_y !== e.linear_y) begin
                  $error("linear_y exp %0d got %0d", e.linear_y, rsp_linear_y);
                  failures++;
               end
               if (rsp_linear_z !== e.linear_z) begin
                  $error("linear_z exp %0d got %0d", e.linear_z, rsp_linear_z);
                  failures++;
               end
               if (rsp_angular_x !== e.angular_x) begin
                  $error("angular_x exp %0d got %0d", e.angular_x, rsp_angular_x);
                  failures++;
               end
               if (rsp_angular_y !== e.angular_y) begin
                  $error("angular_y exp %0d got %0d", e.angular_y, rsp_angular_y);
                  failures++;
               end
               if (rsp_angular_z !== e.angular_z) begin
                  $error("angular_z exp %0d got %0d", e.angular_z, rsp_angular_z);
                  failures++;
               end
               if (rsp_end_x !== e.end_x) begin
                  $error("end_x exp %0d got %0d", e.end_x, rsp_end_x);
                  failures++;
               end
               if (rsp_end_y !== e.end_y) begin
                  $error("end_y exp %0d got %0d", e.end_y, rsp_end_y);
                  failures++;
               end
               if (rsp_end_z !== e.end_z) begin
                  $error("end_z exp %0d got %0d", e.end_z, rsp_end_z);
                  failures++;
               end
               if (rsp_last_column !== e.last_column) begin
                  $error("last_column exp %0d got %0d", e.last_column, rsp_last_column);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            int r;
            r = $urandom_range(99);
            rsp_ready <= 1'b1;
            if (r < 20) stall_left <= $urandom_range(1, 3);
            else if (r < 23) stall_left <= $urandom_range(20, 80);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      failures = 0;
      leg_side = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_angle_ankle_pitch <= '0;
      req_angle_ankle_roll <= '0;
      req_angle_knee_pitch <= '0;
      req_angle_hip_pitch <= '0;
      req_angle_hip_roll <= '0;
      req_angle_hip_yaw <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drain_and_set_side(1'b0);
      run_directed();
      run_random(40);
      drain_and_set_side(1'b1);
      run_directed();
      run_random(40);
      drain_and_set_side(1'b0);
      run_random(30);
      req_valid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
